// File: src/rcbol_pkg.sv
package rcbol_pkg;

	// Table and owner sizing
	localparam int MaxProcs  = 16;
	localparam int ProcW     = $clog2(MaxProcs);
	localparam int NumProcsW = 5;

	// Field widths
	localparam int CoordW = 32;
	localparam int AxisW  = 2;
	localparam int BoxW   = 31;

	// Stream widths
	localparam int STdataW = 136;
	localparam int MTdataW = 8;
	localparam int CfgIdxW = 2;

	// func codes carried on s_tuser
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_NUM_PROCS = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_BOX_X     = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_BOX_Y     = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_BOX_Z     = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load_node;
		logic start_query;
		logic step;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage

// File: src/rcbol_ctrl.sv
module rcbol_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	input  rcbol_pkg::sts_t     sts,
	output logic                s_tready,
	output rcbol_pkg::cmd_t     cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic state_q;
	logic state_d;
	logic acc;

	// Handshake and command decode
	always_comb begin
		s_tready        = (state_q == ST_IDLE);
		acc             = s_tvalid && s_tready;
		cmd.load_node   = acc && (s_tuser == rcbol_pkg::FUNC_LOAD);
		cmd.start_query = acc && (s_tuser == rcbol_pkg::FUNC_QUERY);
		cmd.step        = (state_q == ST_WALK) && !sts.walk_done;
		cmd.emit        = (state_q == ST_WALK) && sts.walk_done && sts.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start_query)
					state_d = ST_WALK;
			end
			ST_WALK: begin
				if (cmd.emit)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// A query always enters the walk
	a_query_walks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_query |=> (state_q == ST_WALK))
		else $error("query accepted but walk not started");

	// No beat is taken while a walk is under way
	a_no_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !(cmd.load_node || cmd.start_query))
		else $error("input accepted during walk");

	// Writing the result ends the walk
	a_emit_idles: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == ST_IDLE))
		else $error("walk did not end after result write");

endmodule

// File: src/rcbol_dp.sv
module rcbol_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rcbol_pkg::cmd_t                      cmd,
	input  logic [rcbol_pkg::STdataW-1:0]        s_tdata,
	input  logic                                 cfg_we,
	input  logic [rcbol_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [rcbol_pkg::BoxW-1:0]           cfg_wdata,
	input  logic                                 m_tready,
	output rcbol_pkg::sts_t                      sts,
	output logic                                 m_tvalid,
	output logic [rcbol_pkg::MTdataW-1:0]        m_tdata
);

	localparam int CW = rcbol_pkg::CoordW;
	localparam int AW = rcbol_pkg::AxisW;
	localparam int PW = rcbol_pkg::ProcW;

	// Pick one of three coordinates; axis code three reads as z
	function automatic logic signed [CW-1:0] coord_sel(
		input logic [AW-1:0]        ax,
		input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y,
		input logic signed [CW-1:0] z
	);
		logic signed [CW-1:0] r;
		if (ax[1])
			r = z;
		else if (ax[0])
			r = y;
		else
			r = x;
		return r;
	endfunction

	// Input beat fields
	logic [PW-1:0]        in_index;
	logic signed [CW-1:0] in_cut;
	logic [AW-1:0]        in_axis;
	logic signed [CW-1:0] in_x, in_y, in_z;
	logic [AW-1:0]        in_check;

	assign in_index = s_tdata[3:0];
	assign in_cut   = s_tdata[35:4];
	assign in_axis  = s_tdata[37:36];
	assign in_x     = s_tdata[69:38];
	assign in_y     = s_tdata[101:70];
	assign in_z     = s_tdata[133:102];
	assign in_check = s_tdata[135:134];

	// Configuration registers
	logic [rcbol_pkg::NumProcsW-1:0] num_procs_q;
	logic [rcbol_pkg::BoxW-1:0]      box_x_q, box_y_q, box_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_procs_q <= rcbol_pkg::NumProcsW'(1);
			box_x_q     <= '0;
			box_y_q     <= '0;
			box_z_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rcbol_pkg::REG_NUM_PROCS:
					num_procs_q <= cfg_wdata[rcbol_pkg::NumProcsW-1:0];
				rcbol_pkg::REG_BOX_X: box_x_q <= cfg_wdata;
				rcbol_pkg::REG_BOX_Y: box_y_q <= cfg_wdata;
				rcbol_pkg::REG_BOX_Z: box_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Node table, written by load beats
	logic signed [CW-1:0] cut_mem  [rcbol_pkg::MaxProcs];
	logic [AW-1:0]        axis_mem [rcbol_pkg::MaxProcs];

	always_ff @(posedge clk) begin
		if (cmd.load_node) begin
			cut_mem[in_index]  <= in_cut;
			axis_mem[in_index] <= in_axis;
		end
	end

	// Box check on the accepted query
	logic signed [CW-1:0]  chk_coord;
	logic [rcbol_pkg::BoxW-1:0] chk_box;
	logic                  mig_d;

	always_comb begin
		chk_coord = coord_sel(in_check, in_x, in_y, in_z);
		if (in_check[1])
			chk_box = box_z_q;
		else if (in_check[0])
			chk_box = box_y_q;
		else
			chk_box = box_x_q;
		mig_d = chk_coord[CW-1] || (chk_coord[CW-2:0] > chk_box);
	end

	// Leaf range end from the clamped processor count
	logic [PW-1:0] last_leaf;

	always_comb begin
		if (num_procs_q == '0)
			last_leaf = '0;
		else if (num_procs_q > rcbol_pkg::NumProcsW'(rcbol_pkg::MaxProcs))
			last_leaf = PW'(rcbol_pkg::MaxProcs - 1);
		else
			last_leaf = PW'(num_procs_q - rcbol_pkg::NumProcsW'(1));
	end

	// Walk state: one tree level per step
	logic signed [CW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic                 mig_q;
	logic [PW-1:0]        start_q, end_q;
	logic [PW-1:0]        mid;
	logic signed [CW-1:0] node_cut;
	logic [AW-1:0]        node_axis;
	logic                 go_low;

	always_comb begin
		mid       = start_q + ((end_q - start_q) >> 1) + PW'(1);
		node_cut  = cut_mem[mid];
		node_axis = axis_mem[mid];
		go_low    = coord_sel(node_axis, pos_x_q, pos_y_q, pos_z_q) < node_cut;
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			pos_x_q <= in_x;
			pos_y_q <= in_y;
			pos_z_q <= in_z;
			mig_q   <= mig_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
		end else if (cmd.start_query) begin
			start_q <= '0;
			end_q   <= last_leaf;
		end else if (cmd.step) begin
			if (go_low)
				end_q <= mid - PW'(1);
			else
				start_q <= mid;
		end
	end

	// Output register
	localparam int MTdataW_L = rcbol_pkg::MTdataW;
	logic                    out_valid_q;
	logic [MTdataW_L-1:0]    out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_data_q <= {3'b000, start_q, mig_q};
	end

	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;
	assign sts.walk_done = (start_q == end_q);
	assign sts.out_free  = !out_valid_q || m_tready;

	// The walk range never inverts
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		start_q <= end_q)
		else $error("walk range inverted");

	// A result is written only when the walk is done and the register is free
	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (sts.walk_done && sts.out_free))
		else $error("result written early or over a pending beat");

	// Each step narrows the range
	a_step_narrows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> ((end_q - start_q) < $past(end_q - start_q)))
		else $error("walk step did not narrow the range");

endmodule

// File: src/rcb_owner_lookup_top.sv
// Loads: one beat per cycle while no walk is under way, no result.
// Queries: the walk runs over the leaves 0..n-1, n being num_procs
// clamped to 1..16; the walk visits one tree level per step. The next beat is
// taken in the cycle after the result is written, so one query is walked at a time.
// A walk that ends while the previous result is still unaccepted waits for m_tready.
// Reset (arst_n low) clears control and configuration; the node table is not cleared.
module rcb_owner_lookup_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// node_index, node_cut, node_axis, pos_x, pos_y, pos_z, check_axis
	input  logic [rcbol_pkg::STdataW-1:0]        s_tdata,
	// func
	input  logic                                 s_tuser,
	// Result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// migrate, owner_proc, zero pad
	output logic [rcbol_pkg::MTdataW-1:0]        m_tdata,
	// Configuration writes
	input  logic                                 cfg_we,
	input  logic [rcbol_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [rcbol_pkg::BoxW-1:0]           cfg_wdata
);

	rcbol_pkg::cmd_t cmd;
	rcbol_pkg::sts_t sts;

	rcbol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	rcbol_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.m_tready  (m_tready),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
